// ===== design/gbfc_pkg.sv =====
// Shared constants and helpers for the GIF block-structure frame counter.
// No dependencies; imported by gif_block_frame_counter_top and the testbench.
`default_nettype none

package gbfc_pkg;

    localparam int SKIP_WIDTH = 10;

    typedef logic [SKIP_WIDTH-1:0] skip_t;
    typedef logic [7:0]            byte_t;

    // Block introducers and flag bits of the GIF stream.
    localparam byte_t INTRO_TRAILER   = 8'h3b;
    localparam byte_t INTRO_EXTENSION = 8'h21;
    localparam byte_t INTRO_IMAGE     = 8'h2c;

    // Header bytes before the packed flags byte, and descriptor bytes before its flags.
    localparam skip_t HEADER_SKIP     = skip_t'(10);
    localparam skip_t IMG_DESC_SKIP   = skip_t'(8);

    typedef enum logic [1:0] {
        STATUS_TRAILER   = 2'd0,
        STATUS_CORRUPT   = 2'd1,
        STATUS_TRUNCATED = 2'd2,
        STATUS_AFTER_IMG = 2'd3
    } end_status_t;

    // Size in bytes of a color table announced by a packed flags byte.
    // Bit 7 enables the table; bits 2:0 give 2^(n+1) entries of three bytes.
    function automatic skip_t table_bytes(input byte_t flags);
        skip_t size;
        size = '0;
        if (flags[7]) begin
            size = skip_t'(6) << flags[2:0];
        end
        return size;
    endfunction

endpackage

`default_nettype wire

// ===== design/gif_block_frame_counter_top.sv =====
// Top level of the GIF block-structure frame counter: byte parser, frame counter
// and result register. Depends on gbfc_pkg.
`default_nettype none

// The block takes a GIF file on the s_ channel, one word per byte, with
// s_last_byte high on the final byte of the file. It walks the logical screen
// header, the global color table, extension blocks and image descriptors with
// their color tables and data sub-blocks, and counts the images it passes.
//
// Exactly one word leaves on the m_ channel per file: when the trailer is met,
// when an unknown introducer is seen, or when the file ends. It carries the
// frame count (saturated to 16 bits) and an end status. Bytes that follow the
// end of parsing are swallowed until a byte marked last re-arms the parser.
//
// Each byte is consumed in the cycle it is accepted; the parse state and the
// counter update in that same clock edge, and the result word appears on m_ in
// the cycle after the byte that ends parsing. Throughput is one byte per cycle
// while s_ready is high. The result sits in an output register. s_ready is high
// while that register is empty or is drained in the same cycle, so a receiver
// that stalls with a result waiting also holds off the input until that word is taken.
//
// Synchronous active-low reset puts the parser in the header phase with the
// counter at one and the output register empty.
module gif_block_frame_counter_top
    import gbfc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_frame_total,
    output logic [1:0]       m_end_status
);

    typedef enum logic [3:0] {
        PH_HEADER      = 4'd0,
        PH_GCT_SKIP    = 4'd1,
        PH_INTRO       = 4'd2,
        PH_AFTER_IMAGE = 4'd3,
        PH_EXT_LABEL   = 4'd4,
        PH_EXT_LEN     = 4'd5,
        PH_EXT_DATA    = 4'd6,
        PH_IMG_DESC    = 4'd7,
        PH_IMG_TABLE   = 4'd8,
        PH_IMG_LEN     = 4'd9,
        PH_IMG_DATA    = 4'd10
    } phase_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam count_t COUNT_MAX   = {COUNT_WIDTH{1'b1}};
    localparam count_t COUNT_RESET = count_t'(1);

    phase_t      phase_reg, phase_next;
    skip_t       skip_reg, skip_next;
    count_t      count_reg, count_next;
    logic        finished_reg, finished_next;

    logic        m_valid_reg;
    logic [15:0] m_frame_total_reg;
    end_status_t m_end_status_reg;

    logic        accept;
    logic        emit;
    end_status_t status;
    logic        count_up, count_down, intro_en;
    skip_t       skip_dec;
    count_t      count_mid;
    logic [31:0] count_wide;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign m_valid       = m_valid_reg;
    assign m_frame_total = m_frame_total_reg;
    assign m_end_status  = m_end_status_reg;

    assign skip_dec = (skip_reg != '0) ? skip_reg - skip_t'(1) : '0;

    always_comb begin
        phase_next    = phase_reg;
        skip_next     = skip_reg;
        finished_next = finished_reg;
        emit          = 1'b0;
        status        = STATUS_TRAILER;
        count_up      = 1'b0;
        count_down    = 1'b0;
        intro_en      = 1'b0;

        unique case (phase_reg)
            PH_HEADER: begin
                if (skip_reg != '0) begin
                    skip_next = skip_dec;
                end else begin
                    skip_next  = skip_t'(2) + table_bytes(s_data_byte);
                    phase_next = PH_GCT_SKIP;
                end
            end
            PH_GCT_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    phase_next = PH_INTRO;
                end
            end
            PH_AFTER_IMAGE: begin
                if (s_data_byte == INTRO_TRAILER) begin
                    emit   = 1'b1;
                    status = STATUS_TRAILER;
                end else begin
                    count_up = 1'b1;
                    intro_en = 1'b1;
                end
            end
            PH_EXT_LABEL: begin
                phase_next = PH_EXT_LEN;
            end
            PH_EXT_LEN: begin
                if (s_data_byte == 8'd0) begin
                    phase_next = PH_INTRO;
                end else begin
                    skip_next  = skip_t'(s_data_byte);
                    phase_next = PH_EXT_DATA;
                end
            end
            PH_EXT_DATA: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    phase_next = PH_EXT_LEN;
                end
            end
            PH_IMG_DESC: begin
                if (skip_reg != '0) begin
                    skip_next = skip_dec;
                end else begin
                    skip_next  = table_bytes(s_data_byte) + skip_t'(1);
                    phase_next = PH_IMG_TABLE;
                end
            end
            PH_IMG_TABLE: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    phase_next = PH_IMG_LEN;
                end
            end
            PH_IMG_LEN: begin
                if (s_data_byte == 8'd0) begin
                    phase_next = PH_AFTER_IMAGE;
                end else begin
                    skip_next  = skip_t'(s_data_byte);
                    phase_next = PH_IMG_DATA;
                end
            end
            PH_IMG_DATA: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    phase_next = PH_IMG_LEN;
                end
            end
            default: begin
                intro_en = 1'b1;
            end
        endcase

        // Introducer decode, shared by the intro phase and the byte after an image.
        if (intro_en) begin
            priority if (s_data_byte == INTRO_TRAILER) begin
                count_down = 1'b1;
                emit       = 1'b1;
                status     = STATUS_TRAILER;
            end else if (s_data_byte == INTRO_EXTENSION) begin
                phase_next = PH_EXT_LABEL;
            end else if (s_data_byte == INTRO_IMAGE) begin
                phase_next = PH_IMG_DESC;
                skip_next  = IMG_DESC_SKIP;
            end else begin
                count_down = 1'b1;
                emit       = 1'b1;
                status     = STATUS_CORRUPT;
            end
        end

        // End of file before parsing ended on its own.
        if (!emit && s_last_byte) begin
            emit = 1'b1;
            if (phase_next == PH_AFTER_IMAGE) begin
                status = STATUS_AFTER_IMG;
            end else begin
                count_down = 1'b1;
                status     = STATUS_TRUNCATED;
            end
        end

        // Raise then lower, each saturating, in the order the parser applies them.
        count_mid  = (count_up && count_reg != COUNT_MAX) ? count_reg + count_t'(1) : count_reg;
        count_next = (count_down && count_mid != '0) ? count_mid - count_t'(1) : count_mid;

        if (emit) begin
            finished_next = 1'b1;
        end

        // A byte after the end is swallowed; the parsed values above are unused then.
        if (finished_reg) begin
            emit = 1'b0;
        end
    end

    assign count_wide = 32'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            skip_reg     <= HEADER_SKIP;
            count_reg    <= COUNT_RESET;
            finished_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // A new result can only be taken in while the register is empty or draining.
            if (accept && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (s_last_byte) begin
                    // The final byte of a file always re-arms the parser.
                    phase_reg    <= PH_HEADER;
                    skip_reg     <= HEADER_SKIP;
                    count_reg    <= COUNT_RESET;
                    finished_reg <= 1'b0;
                end else if (!finished_reg) begin
                    phase_reg    <= phase_next;
                    skip_reg     <= skip_next;
                    count_reg    <= count_next;
                    finished_reg <= finished_next;
                end
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_frame_total_reg <= (count_wide > 32'h0000_ffff) ? 16'hffff : count_wide[15:0];
            m_end_status_reg  <= status;
        end
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for gif_block_frame_counter_top: builds GIF byte streams,
// predicts the frame count and end status of each file, and checks every result word.
// Depends on gbfc_pkg and the block's RTL only.
module testbench
    import gbfc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted word on either channel before the run is abandoned.
    localparam int unsigned STALL_LIMIT = 5000;

    // Parse phases of the predictor, one per kind of byte the parser can be waiting for.
    typedef enum logic [3:0] {
        P_HEADER, P_GCT, P_INTRO, P_AFTER_IMG, P_EXT_LABEL, P_EXT_LEN,
        P_EXT_DATA, P_DESC, P_LCT, P_IMG_LEN, P_IMG_DATA
    } phase_t;

    // The scoreboard keeps its own copy of the parser state. Every byte word accepted
    // by the block is replayed here; a file that ends parsing queues the frame count
    // and status that the block must send.
    class gif_frame_tally;
        phase_t      phase;
        int unsigned left;
        logic [15:0] frames;
        bit          done;
        end_status_t code;

        logic [15:0] awaited_total[$];
        end_status_t awaited_status[$];

        int unsigned failures;
        int unsigned predicted;
        int unsigned results_seen;
        int unsigned status_hits[4];

        function new();
            failures = 0;
            predicted = 0;
            results_seen = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
            rearm();
        endfunction

        function void rearm();
            phase = P_HEADER;
            left = 32'(HEADER_SKIP);
            frames = 16'd1;
            done = 0;
            code = STATUS_TRAILER;
        endfunction

        function int unsigned palette_size(input byte_t flags);
            if (!flags[7]) begin
                return 0;
            end
            return 3 * (2 << flags[2:0]);
        endfunction

        function void raise_count();
            if (frames != 16'hffff) begin
                frames++;
            end
        endfunction

        function void lower_count();
            if (frames != 16'd0) begin
                frames--;
            end
        endfunction

        function void stop(input end_status_t s);
            done = 1;
            code = s;
        endfunction

        function void introducer(input byte_t b);
            case (b)
                INTRO_TRAILER: begin
                    lower_count();
                    stop(STATUS_TRAILER);
                end
                INTRO_EXTENSION: begin
                    phase = P_EXT_LABEL;
                end
                INTRO_IMAGE: begin
                    phase = P_DESC;
                    left = 32'(IMG_DESC_SKIP);
                end
                default: begin
                    lower_count();
                    stop(STATUS_CORRUPT);
                end
            endcase
        endfunction

        function void consume(input byte_t b);
            case (phase)
                P_HEADER: begin
                    if (left > 0) begin
                        left--;
                    end else begin
                        left = 2 + palette_size(b);
                        phase = P_GCT;
                    end
                end
                P_GCT: begin
                    if (left > 0) left--;
                    if (left == 0) phase = P_INTRO;
                end
                P_AFTER_IMG: begin
                    if (b == INTRO_TRAILER) begin
                        stop(STATUS_TRAILER);
                    end else begin
                        raise_count();
                        introducer(b);
                    end
                end
                P_EXT_LABEL: begin
                    phase = P_EXT_LEN;
                end
                P_EXT_LEN: begin
                    if (b == 8'd0) begin
                        phase = P_INTRO;
                    end else begin
                        left = 32'(b);
                        phase = P_EXT_DATA;
                    end
                end
                P_EXT_DATA: begin
                    if (left > 0) left--;
                    if (left == 0) phase = P_EXT_LEN;
                end
                P_DESC: begin
                    if (left > 0) begin
                        left--;
                    end else begin
                        left = palette_size(b) + 1;
                        phase = P_LCT;
                    end
                end
                P_LCT: begin
                    if (left > 0) left--;
                    if (left == 0) phase = P_IMG_LEN;
                end
                P_IMG_LEN: begin
                    if (b == 8'd0) begin
                        phase = P_AFTER_IMG;
                    end else begin
                        left = 32'(b);
                        phase = P_IMG_DATA;
                    end
                end
                P_IMG_DATA: begin
                    if (left > 0) left--;
                    if (left == 0) phase = P_IMG_LEN;
                end
                default: begin
                    introducer(b);
                end
            endcase
        endfunction

        function void note_byte(input byte_t b, input bit last);
            if (done) begin
                if (last) rearm();
                return;
            end
            consume(b);
            if (!done && last) begin
                if (phase == P_AFTER_IMG) begin
                    stop(STATUS_AFTER_IMG);
                end else begin
                    lower_count();
                    stop(STATUS_TRUNCATED);
                end
            end
            if (done) begin
                awaited_total.push_back(frames);
                awaited_status.push_back(code);
                predicted++;
                if (last) rearm();
            end
        endfunction

        function void check_result(input logic [15:0] total, input logic [1:0] status);
            logic [15:0] want_total;
            end_status_t want_status;
            if (awaited_total.size() == 0) begin
                $error("unexpected result word: frame_total=%0d end_status=%0d", total, status);
                failures++;
                return;
            end
            want_total = awaited_total.pop_front();
            want_status = awaited_status.pop_front();
            results_seen++;
            status_hits[want_status]++;
            if (total !== want_total) begin
                $error("frame_total: expected %0d, actual %0d", want_total, total);
                failures++;
            end
            if (status !== want_status) begin
                $error("end_status: expected %0d, actual %0d", want_status, status);
                failures++;
            end
        endfunction

        function int unsigned outstanding();
            return awaited_total.size();
        endfunction

        function void flush_leftovers();
            while (awaited_total.size() != 0) begin
                $error("result never arrived: frame_total=%0d end_status=%0d",
                       awaited_total[0], awaited_status[0]);
                failures++;
                void'(awaited_total.pop_front());
                void'(awaited_status.pop_front());
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_last_byte = 1'b0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [15:0] m_frame_total;
    wire  [1:0]  m_end_status;

    gif_frame_tally board;

    // The file being assembled before it is streamed into the block.
    byte_t file_q[$];
    int unsigned words_sent = 0;
    int unsigned files_sent = 0;

    // While set, neither side idles: the sender streams back to back and the
    // receiver keeps ready high.
    bit calm = 1'b0;

    gif_block_frame_counter_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_total (m_frame_total),
        .m_end_status  (m_end_status)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The receiver drops ready in roughly a third of the cycles unless the run is calm.
    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 32);
    end

    // Both channels are sampled right after the edge, before any nonblocking update of
    // this time step lands, so the values seen are the ones the block saw at the edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.note_byte(s_data_byte, s_last_byte);
        end
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_frame_total, m_end_status);
        end
    end

    // The watchdog ends the run when neither channel has moved a word for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("FAIL gif_block_frame_counter_top");
        $finish;
    end

    // Offers one byte word and holds it until the block takes it. Idle cycles are
    // inserted in front of the word at random so gaps hit every parse phase.
    task automatic send_word(input byte_t b, input bit last);
        if (!calm) begin
            while ($urandom_range(0, 99) < 32) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        words_sent++;
    endtask

    // Streams the assembled bytes; with close set, the final byte carries the last mark.
    task automatic send_file(input bit close);
        foreach (file_q[i]) begin
            send_word(file_q[i], close && (i == file_q.size() - 1));
        end
        file_q.delete();
        if (close) files_sent++;
    endtask

    task automatic add_random(input int unsigned n);
        repeat (n) file_q.push_back(byte_t'($urandom_range(0, 255)));
    endtask

    // Packed flags with a random table bit; the table is mostly small and now and then
    // the largest one the format allows.
    function automatic byte_t pick_flags();
        byte_t f;
        f = byte_t'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 4) begin
            f[2:0] = 3'd7;
        end else begin
            f[2:0] = 3'($urandom_range(0, 2));
        end
        return f;
    endfunction

    // Logical screen header: ten bytes before the flags, two after, then the table.
    task automatic add_header(input byte_t flags);
        add_random(10);
        file_q.push_back(flags);
        add_random(2 + board.palette_size(flags));
    endtask

    // A chain of sub-blocks closed by a zero length; lengths are mostly short.
    task automatic add_sub_blocks();
        int unsigned len;
        repeat ($urandom_range(0, 3)) begin
            len = ($urandom_range(0, 29) == 0) ? 255 : $urandom_range(1, 10);
            file_q.push_back(byte_t'(len));
            add_random(len);
        end
        file_q.push_back(8'd0);
    endtask

    task automatic add_extension();
        file_q.push_back(INTRO_EXTENSION);
        add_random(1);
        add_sub_blocks();
    endtask

    // Image descriptor, optional local table, code size and data; without data the
    // image holds only the terminating zero.
    task automatic add_image(input byte_t flags, input bit with_data);
        file_q.push_back(INTRO_IMAGE);
        add_random(8);
        file_q.push_back(flags);
        add_random(board.palette_size(flags) + 1);
        if (with_data) begin
            add_sub_blocks();
        end else begin
            file_q.push_back(8'd0);
        end
    endtask

    // Most files are well formed with random content; the rest end in junk after the
    // trailer, a bad introducer, a cut at a random byte, or are plain noise.
    task automatic build_random_file();
        int unsigned kind;
        int unsigned cut;
        bit ends_in_image;
        byte_t bad;
        kind = $urandom_range(0, 99);
        ends_in_image = 0;
        add_header(pick_flags());
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 2) == 0) begin
                add_extension();
                ends_in_image = 0;
            end else begin
                add_image(pick_flags(), 1);
                ends_in_image = 1;
            end
        end
        if (kind < 45) begin
            file_q.push_back(INTRO_TRAILER);
        end else if (kind < 60) begin
            // The last mark lands on the image terminator when there is one.
            if (!ends_in_image) file_q.push_back(INTRO_TRAILER);
        end else if (kind < 70) begin
            file_q.push_back(INTRO_TRAILER);
            add_random($urandom_range(1, 6));
        end else if (kind < 80) begin
            do begin
                bad = byte_t'($urandom_range(0, 255));
            end while (bad == INTRO_TRAILER || bad == INTRO_EXTENSION || bad == INTRO_IMAGE);
            file_q.push_back(bad);
            add_random($urandom_range(0, 4));
        end else if (kind < 95) begin
            cut = $urandom_range(1, file_q.size());
            while (file_q.size() > cut) void'(file_q.pop_back());
        end else begin
            file_q.delete();
            add_random($urandom_range(1, 40));
        end
    endtask

    initial begin
        board = new();

        // Synchronous reset is held low at the start, then released.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed files. A file cut inside the header is truncated.
        add_random(3);
        send_file(1);
        // A one-byte file of all ones.
        file_q.push_back(8'hff);
        send_file(1);
        // Trailer right after the header takes the count to zero.
        add_header(8'h00);
        file_q.push_back(INTRO_TRAILER);
        send_file(1);
        // The stream ends on an image terminator: count kept, status after-image.
        add_header(8'h80);
        add_image(8'h00, 1);
        send_file(1);
        // Extension, two images with a local table on the first, then the trailer.
        add_header(8'h01);
        add_extension();
        add_image(8'h81, 1);
        add_image(8'h00, 1);
        file_q.push_back(INTRO_TRAILER);
        send_file(1);
        // A zero byte where an introducer belongs.
        add_header(8'h00);
        file_q.push_back(8'h00);
        send_file(1);
        // Bad introducer after an image: raised, then lowered again.
        add_header(8'h00);
        add_image(8'h7f, 0);
        file_q.push_back(8'hff);
        add_random(2);
        send_file(1);
        // Stream ends right after an extension, which counts as truncated.
        add_header(8'h00);
        add_extension();
        send_file(1);
        // Trailer after an extension.
        add_header(8'h00);
        add_extension();
        file_q.push_back(INTRO_TRAILER);
        send_file(1);
        // Trailer followed by junk, which is swallowed until the last mark.
        add_header(8'h00);
        add_image(8'h00, 0);
        file_q.push_back(INTRO_TRAILER);
        add_random(3);
        send_file(1);

        // Random files with idling on both sides.
        while (words_sent < 1700) begin
            build_random_file();
            send_file(1);
        end

        // The last stretch of files runs with no idling on either side.
        calm = 1'b1;
        while (words_sent < 1950) begin
            build_random_file();
            send_file(1);
        end
        calm = 1'b0;

        // Drain: wait for every awaited result, then keep watching for stray words.
        s_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        board.flush_leftovers();

        $display("Streamed %0d bytes in %0d files, the last ones back to back with no stalls.",
                 words_sent, files_sent);
        $display("Checked %0d results: %0d trailer, %0d corrupt, %0d truncated, %0d after image.",
                 board.results_seen, board.status_hits[STATUS_TRAILER],
                 board.status_hits[STATUS_CORRUPT], board.status_hits[STATUS_TRUNCATED],
                 board.status_hits[STATUS_AFTER_IMG]);
        if (board.failures == 0) begin
            $display("PASS gif_block_frame_counter_top");
        end else begin
            $display("FAIL gif_block_frame_counter_top");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/gbfc_pkg.sv
design/gif_block_frame_counter_top.sv
bench/testbench.sv
